// ===== rtl/sem_pkg.sv =====
`default_nettype none

package sem_pkg;

	localparam int PIX_W      = 8;
	localparam int EDGE_SHIFT = 6;
	localparam int EDGE_W     = 5;
	// One side of a gradient: a + 2*b + c of three pixels
	localparam int SUM_W      = PIX_W + 2;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH   = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	// One line store entry: the pixel two rows up and the pixel one row up
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
	} line_pair_t;

	// Memory access from the pipeline to the line store
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sem_line_mem.sv =====
`default_nettype none

module sem_line_mem #(
	parameter int DEPTH = 256
) (
	input  wire                             clk,
	input  wire sem_pkg::mem_ctrl_t         ctrl,
	input  wire        [$clog2(DEPTH)-1:0]  rd_addr,
	output sem_pkg::line_pair_t             rd_data,
	input  wire        [$clog2(DEPTH)-1:0]  wr_addr,
	input  wire sem_pkg::line_pair_t        wr_data
);

	sem_pkg::line_pair_t mem_q [DEPTH];
	sem_pkg::line_pair_t rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// read data holds while the pipeline is frozen
		if (ctrl.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ===== rtl/sobel_edge_magnitude_stream_unit.sv =====
`default_nettype none

// Streaming 3x3 Sobel edge detector. Grayscale pixels arrive in raster order,
// one beat per pixel; for every pixel that completes an interior 3x3 window
// (row >= 2 and column >= 2) one result beat carries (|gx|+|gy|) >> 6 and a
// flag on the final result of the frame. Border pixels give no result beat.
// Throughput is one pixel per clock while unstalled: the two previous rows
// live in a single line store (one read and one write port, registered
// read), read when a pixel is taken and written back as it leaves stage 1; a
// given column is revisited no sooner than three pixels later, so the
// read-modify-write never collides. The pipeline advances as a whole;
// pixel_stall is high only while a result waits on result_stall. Writing
// either configuration register (index 0 line width, clamped to 3..MAX_WIDTH;
// index 1 frame height, values below 3 act as 3) restarts the frame at row 0,
// column 0; the user must make writes only while idle (not enforced by the
// block); cfg_ready is always high. No clearing pass after reset: rows 0 and
// 1 of every frame fill the line store before a result uses it.

module sobel_edge_magnitude_stream_unit #(
	parameter int MAX_WIDTH = 256
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// pixel channel
	input  wire                                  pixel_valid,
	output logic                                 pixel_stall,
	input  wire  [sem_pkg::PIX_W-1:0]            pixel_in,
	// result channel
	output logic                                 result_valid,
	input  wire                                  result_stall,
	output logic [sem_pkg::EDGE_W-1:0]           edge_value,
	output logic                                 last_of_frame,
	// configuration write channel
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [sem_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [sem_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int MWB = $clog2(MAX_WIDTH + 1);
	// compare domain wide enough for both the register and MAX_WIDTH
	localparam int XW  = (MWB > sem_pkg::CFG_DATA_W) ? MWB : sem_pkg::CFG_DATA_W;
	localparam int PW  = sem_pkg::PIX_W;
	localparam int SW  = sem_pkg::SUM_W;

	// ---------------- configuration ----------------
	logic [sem_pkg::CFG_DATA_W-1:0] line_width_q;
	logic [7:0]                     frame_height_q;
	logic                           cfg_wr;
	logic                           cfg_hit;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		case (cfg_index)
			sem_pkg::CFG_LINE_WIDTH,
			sem_pkg::CFG_FRAME_HEIGHT: cfg_hit = 1'b1;
			default:                   cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= sem_pkg::CFG_DATA_W'(16);
			frame_height_q <= 8'd16;
		end else if (cfg_wr) begin
			case (cfg_index)
				sem_pkg::CFG_LINE_WIDTH:   line_width_q   <= cfg_data;
				sem_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// effective frame size
	logic [XW-1:0] lw_x;
	logic [XW-1:0] eff_w;
	logic [7:0]    eff_h;

	assign lw_x = XW'(line_width_q);

	always_comb begin
		if (lw_x < XW'(3)) begin
			eff_w = XW'(3);
		end else if (lw_x > XW'(MAX_WIDTH)) begin
			eff_w = XW'(MAX_WIDTH);
		end else begin
			eff_w = lw_x;
		end
		eff_h = (frame_height_q < 8'd3) ? 8'd3 : frame_height_q;
	end

	// ---------------- pipeline control ----------------
	logic adv;
	logic pix_acc;

	// whole pipeline moves when the result register is free or being taken
	assign adv         = !result_valid || !result_stall;
	assign pixel_stall = !adv;
	assign pix_acc     = pixel_valid && !pixel_stall;

	// ---------------- stage 0: raster position, line store read ----------------
	logic [AW-1:0] col_q;
	logic [7:0]    row_q;
	logic          col_end;
	logic          row_end;

	assign col_end = (XW'(col_q) == eff_w - XW'(1));
	assign row_end = (row_q == eff_h - 8'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr && cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? 8'd0 : row_q + 8'd1;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// ---------------- stage 1: window, write-back, gradient sums ----------------
	logic          valid_s1;
	logic          emit_s1;
	logic          last_s1;
	logic [AW-1:0] col_s1;
	logic [PW-1:0] pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			col_s1  <= col_q;
			pix_s1  <= pixel_in;
			emit_s1 <= (row_q >= 8'd2) && (col_q >= AW'(2));
			last_s1 <= row_end && col_end;
		end
	end

	sem_pkg::mem_ctrl_t  mem_ctrl;
	sem_pkg::line_pair_t rd_pair;
	sem_pkg::line_pair_t wr_pair;

	assign mem_ctrl.rd_en = pix_acc;
	assign mem_ctrl.wr_en = valid_s1 && adv;
	// rows shift down by one: mid becomes top, the new pixel becomes mid
	assign wr_pair.top    = rd_pair.mid;
	assign wr_pair.mid    = pix_s1;

	sem_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_mem (
		.clk     (clk),
		.ctrl    (mem_ctrl),
		.rd_addr (col_q),
		.rd_data (rd_pair),
		.wr_addr (col_s1),
		.wr_data (wr_pair)
	);

	// window columns c-1 (m*) and c-2 (l*): index 0 top, 1 mid, 2 bottom
	logic [PW-1:0] m_q [3];
	logic [PW-1:0] l_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				m_q[i] <= '0;
				l_q[i] <= '0;
			end
		end else if (valid_s1 && adv) begin
			for (int i = 0; i < 3; i++) begin
				l_q[i] <= m_q[i];
			end
			m_q[0] <= rd_pair.top;
			m_q[1] <= rd_pair.mid;
			m_q[2] <= pix_s1;
		end
	end

	logic [SW-1:0] px_c, nx_c, py_c, ny_c;

	always_comb begin
		px_c = SW'(rd_pair.top) + {1'b0, rd_pair.mid, 1'b0} + SW'(pix_s1);
		nx_c = SW'(l_q[0]) + {1'b0, l_q[1], 1'b0} + SW'(l_q[2]);
		py_c = SW'(l_q[2]) + {1'b0, m_q[2], 1'b0} + SW'(pix_s1);
		ny_c = SW'(l_q[0]) + {1'b0, m_q[0], 1'b0} + SW'(rd_pair.top);
	end

	// ---------------- stage 2: magnitude ----------------
	logic          valid_s2;
	logic          last_s2;
	logic [SW-1:0] px_s2, nx_s2, py_s2, ny_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			px_s2   <= px_c;
			nx_s2   <= nx_c;
			py_s2   <= py_c;
			ny_s2   <= ny_c;
			last_s2 <= last_s1;
		end
	end

	logic [SW-1:0] gx_abs, gy_abs;
	logic [SW:0]   mag_sum;

	always_comb begin
		gx_abs  = (px_s2 >= nx_s2) ? px_s2 - nx_s2 : nx_s2 - px_s2;
		gy_abs  = (py_s2 >= ny_s2) ? py_s2 - ny_s2 : ny_s2 - py_s2;
		mag_sum = {1'b0, gx_abs} + {1'b0, gy_abs};
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			edge_value    <= mag_sum[sem_pkg::EDGE_SHIFT +: sem_pkg::EDGE_W];
			last_of_frame <= last_s2;
		end
	end

	// ---------------- assertions ----------------
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(col_q) < eff_w)
		else $error("column counter beyond line width");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < eff_h)
		else $error("row counter beyond frame height");

	a_no_rmw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctrl.rd_en && mem_ctrl.wr_en) |-> (col_q != col_s1))
		else $error("line store read and write hit the same column");

	a_result_needs_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s2))
		else $error("result raised without a magnitude in flight");

endmodule

`default_nettype wire
